@@ hdl/ipd_uri_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_uri_pkg: shared types and constants for the request URI parser
// Character codes, the input and result word layouts.
// ----------------------------------------------------------------------------
package ipd_uri_pkg;

   // characters recognized in the modem stream
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_D     = 8'h44;

   // tag store depth
   localparam int TAG_LEN = 3;

   // input word operations
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // input word
   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_word_type;

   // result word
   typedef struct packed {
      logic       uri_byte_valid;
      logic [7:0] uri_byte;
      logic [5:0] uri_index;
      logic       request_done;
      logic [6:0] uri_length;
      logic       uri_overflow;
      logic [2:0] parser_phase;
   } rsp_word_type;

endpackage
`default_nettype wire

@@ hdl/ipd_uri_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_uri_req_if / ipd_uri_rsp_if: valid/ready channels of the URI parser
// One word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ipd_uri_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface ipd_uri_rsp_if;
   logic       valid;
   logic       ready;
   logic       uri_byte_valid;
   logic [7:0] uri_byte;
   logic [5:0] uri_index;
   logic       request_done;
   logic [6:0] uri_length;
   logic       uri_overflow;
   logic [2:0] parser_phase;

   modport source (output valid, output uri_byte_valid, output uri_byte,
                   output uri_index, output request_done, output uri_length,
                   output uri_overflow, output parser_phase, input ready);
   modport sink   (input valid, input uri_byte_valid, input uri_byte,
                   input uri_index, input request_done, input uri_length,
                   input uri_overflow, input parser_phase, output ready);
endinterface
`default_nettype wire

@@ hdl/ipd_uri_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_uri_fsm: parser state machine and result register
// Steps the '+IPD' parse on one byte per enabled cycle and registers the
// result word for that byte.
// ----------------------------------------------------------------------------
module ipd_uri_fsm
   import ipd_uri_pkg::*;
#(
   parameter int URI_MAX = 64,
   parameter int CNT_W   = 7
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               step,
   input  wire req_word_type word_in,
   output rsp_word_type      result_ff
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_TAG    = 3'd1,
      PH_LINK   = 3'd2,
      PH_LEN    = 3'd3,
      PH_METHOD = 3'd4,
      PH_URI    = 3'd5
   } phase_type;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(URI_MAX);
   localparam logic [CNT_W-1:0] CNT_TAG = CNT_W'(TAG_LEN);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       tag_ff [TAG_LEN];
   logic             tag_we;
   logic             ovf_ff, ovf_in;
   rsp_word_type     result_in;
   logic             tag_ipd;

   assign tag_ipd = (tag_ff[0] == CHAR_I) && (tag_ff[1] == CHAR_P) && (tag_ff[2] == CHAR_D);

   // next state and result for the current byte
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      tag_we    = 1'b0;
      result_in = '0;
      if (word_in.op == OP_RESTART) begin
         phase_in = PH_IDLE;
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (word_in.data_byte == CHAR_PLUS) begin
                  phase_in = PH_TAG;
                  count_in = '0;
               end
            end
            PH_TAG: begin
               if (word_in.data_byte == CHAR_COMMA || count_ff >= CNT_TAG) begin
                  count_in = '0;
                  phase_in = tag_ipd ? PH_LINK : PH_IDLE;
               end else begin
                  tag_we   = 1'b1;
                  count_in = count_ff + CNT_ONE;
               end
            end
            PH_LINK: begin
               if (word_in.data_byte == CHAR_COMMA) phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (word_in.data_byte == CHAR_COLON) phase_in = PH_METHOD;
            end
            PH_METHOD: begin
               if (word_in.data_byte == CHAR_SLASH) begin
                  phase_in = PH_URI;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
            PH_URI: begin
               if (word_in.data_byte == CHAR_SPACE) begin
                  result_in.request_done = 1'b1;
                  result_in.uri_length   = 7'(count_ff);
                  result_in.uri_overflow = ovf_ff;
                  phase_in = PH_IDLE;
                  count_in = '0;
               end else if (count_ff < CNT_MAX) begin
                  result_in.uri_byte_valid = 1'b1;
                  result_in.uri_byte       = word_in.data_byte;
                  result_in.uri_index      = 6'(count_ff);
                  count_in = count_ff + CNT_ONE;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
         endcase
         // running length while inside the URI
         if (phase_in == PH_URI) begin
            result_in.uri_length   = 7'(count_in);
            result_in.uri_overflow = ovf_in;
         end
      end
      result_in.parser_phase = phase_in;
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         for (int i = 0; i < TAG_LEN; i++) tag_ff[i] <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (tag_we) tag_ff[count_ff[1:0]] <= word_in.data_byte;
      end
      if (step) result_ff <= result_in;
   end

endmodule
`default_nettype wire

@@ hdl/ipd_request_uri_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_request_uri_parser_unit: modem request URI extractor
// Watches received bytes for '+IPD,<link>,<len>:<method> /<uri> ' and
// returns a result word per input word with any URI byte and request status.
// ----------------------------------------------------------------------------
// Usage: every accepted request word (a byte or a restart) yields exactly one
// response word, in order. The unit takes one word per clock while the sink
// keeps up; a word passes an input register and then the parser step into the
// result register, from which its response is taken at a clock edge when the
// sink is ready. The result register advances only when it is empty or being
// taken, and the input register only when it is empty or its word steps, so a
// stalled sink holds two words in flight before ready drops. URI bytes past
// URI_MAX are dropped and reported through uri_overflow.
module ipd_request_uri_parser_unit
   import ipd_uri_pkg::*;
#(
   parameter int URI_MAX = 64
) (
   input  wire             clock,
   input  wire             reset,
   ipd_uri_req_if.sink     req_if,
   ipd_uri_rsp_if.source   rsp_if
);

   localparam int CNT_W = $clog2(URI_MAX + 1);

   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   logic         step;
   logic         req_take;
   rsp_word_type result;

   // result register free, so the held word may step
   assign step     = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || step;

   // input register and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) in_valid_ff <= req_if.valid;
         if (step) out_valid_ff <= 1'b1;
         else if (rsp_if.ready) out_valid_ff <= 1'b0;
      end
      if (req_take) begin
         in_word_ff.op        <= req_if.op;
         in_word_ff.data_byte <= req_if.data_byte;
      end
   end

   ipd_uri_fsm #(
      .URI_MAX (URI_MAX),
      .CNT_W   (CNT_W)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .word_in   (in_word_ff),
      .result_ff (result)
   );

   // response channel
   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.uri_byte_valid = result.uri_byte_valid;
   assign rsp_if.uri_byte       = result.uri_byte;
   assign rsp_if.uri_index      = result.uri_index;
   assign rsp_if.request_done   = result.request_done;
   assign rsp_if.uri_length     = result.uri_length;
   assign rsp_if.uri_overflow   = result.uri_overflow;
   assign rsp_if.parser_phase   = result.parser_phase;

endmodule
`default_nettype wire
